>>> src/ttf_pkg.sv
// Shared widths, sequencer states and operand selects for the triangle tangent frame block.
// No dependencies; every other file of the block refers to this package.
package ttf_pkg;

    localparam int PosW = 32;
    localparam int NrmW = 16;
    localparam int TanW = 16;
    localparam int BitW = 32;

    localparam logic signed [31:0] Sat31 = 32'sh7FFF_FFFF;
    localparam logic [31:0] LimPos = 32'h7FFF_FFFF;
    localparam logic [31:0] LimNeg = 32'h8000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DELTA,
        ST_PRE,
        ST_SCALE_MAX,
        ST_SCALE_WR,
        ST_BSET,
        ST_DIV,
        ST_BFIN,
        ST_DOT,
        ST_ND,
        ST_SQ,
        ST_SQRT,
        ST_TSET,
        ST_TFIN,
        ST_CROSS,
        ST_SDOT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SRC_TNUM,
        SRC_BNUM,
        SRC_W
    } t_src;

endpackage

>>> src/ttf_vtx_if.sv
// Vertex request channel: valid/ready handshake with position, texture coordinate and normal.
// Depends on ttf_pkg for the field widths.
interface ttf_vtx_if;
    logic valid;
    logic ready;
    logic signed [ttf_pkg::PosW-1:0] pos_x;
    logic signed [ttf_pkg::PosW-1:0] pos_y;
    logic signed [ttf_pkg::PosW-1:0] pos_z;
    logic signed [ttf_pkg::PosW-1:0] tex_u;
    logic signed [ttf_pkg::PosW-1:0] tex_v;
    logic signed [ttf_pkg::NrmW-1:0] norm_x;
    logic signed [ttf_pkg::NrmW-1:0] norm_y;
    logic signed [ttf_pkg::NrmW-1:0] norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
                  output ready);
endinterface

>>> src/ttf_res_if.sv
// Result request channel: valid/ready handshake with tangent, bitangent and flags.
// Depends on ttf_pkg for the field widths.
interface ttf_res_if;
    logic valid;
    logic ready;
    logic signed [ttf_pkg::TanW-1:0] tan_x;
    logic signed [ttf_pkg::TanW-1:0] tan_y;
    logic signed [ttf_pkg::TanW-1:0] tan_z;
    logic signed [ttf_pkg::BitW-1:0] bitan_x;
    logic signed [ttf_pkg::BitW-1:0] bitan_y;
    logic signed [ttf_pkg::BitW-1:0] bitan_z;
    logic degenerate;
    logic last_of_triangle;

    modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
                    last_of_triangle, input ready);
    modport sink (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
                  last_of_triangle, output ready);
endinterface

>>> src/triangle_tangent_frame.sv
// Top level of the triangle tangent frame block: sequencer, shared multiply-accumulate unit
// and shared compare-subtract unit. Depends on ttf_pkg, ttf_vtx_if and ttf_res_if.
//
// Usage: vertices arrive as requests on i_vtx, three per triangle. The first two are taken in
// one cycle each and only stored. The third starts the triangle computation; i_vtx.ready stays
// low until all three results of the triangle have been taken on o_res.
// Results leave on o_res in vertex order, the third with last_of_triangle set. The time a
// triangle takes is set by the one-bit-per-cycle restoring divider (bitangent and tangent
// normalization) and the square root, which share one compare-subtract unit, and by the
// single multiplier that forms every product in turn.
// A zero UV determinant skips the arithmetic and gives three zero results right away.
// While o_res.ready is low the current result is held on o_res and nothing advances.
// Reset returns the sequencer to idle and the vertex count to the start of a triangle.
module triangle_tangent_frame (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttf_vtx_if.sink   i_vtx,
    ttf_res_if.source o_res
);

    ttf_pkg::t_state r_state;
    ttf_pkg::t_state n_state;
    ttf_pkg::t_src   r_src;

    logic [1:0] r_phase;
    logic [4:0] r_cnt;
    logic [1:0] r_idx;
    logic [1:0] r_vtx;
    logic       r_div_tan;
    logic       r_degen;

    logic signed [31:0] r_pos  [9];
    logic signed [31:0] r_uv   [6];
    logic signed [15:0] r_nrm  [9];
    logic signed [31:0] r_dlt  [10];
    logic signed [63:0] r_det;
    logic signed [63:0] r_tnum [3];
    logic signed [63:0] r_bnum [3];
    logic signed [65:0] r_acc;
    logic signed [31:0] r_tdir [3];
    logic signed [31:0] r_bdir [3];
    logic signed [31:0] r_bit  [3];
    logic signed [35:0] r_w    [3];
    logic signed [48:0] r_dot;
    logic signed [15:0] r_t    [3];
    logic signed [31:0] r_c    [3];
    logic signed [6:0]  r_sh;
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_bitm;
    logic [63:0] r_rem;
    logic [63:0] r_dd;
    logic [31:0] r_dlo;
    logic [31:0] r_q;

    logic signed [32:0] mac_a;
    logic signed [32:0] mac_b;
    logic               mac_clr;
    logic               mac_sub;
    logic               mac_shl;
    logic signed [65:0] mac_prod;
    logic signed [65:0] mac_term;
    logic signed [65:0] n_acc;

    logic [64:0] cs_a;
    logic [64:0] cs_b;
    logic        cs_ge;
    logic [64:0] cs_diff;

    logic       vtx_acc;
    logic [1:0] slot;
    logic [4:0] div_last;

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'(ttf_pkg::Sat31)) begin
            return ttf_pkg::Sat31;
        end else if (d < -33'(ttf_pkg::Sat31)) begin
            return -ttf_pkg::Sat31;
        end
        return $signed(d[31:0]);
    endfunction

    function automatic logic [63:0] mag(input logic signed [65:0] x);
        logic [65:0] u;
        u = x[65] ? 66'(-x) : 66'(x);
        return u[63:0];
    endfunction

    function automatic logic [5:0] msb64(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [3:0] vidx(input logic [1:0] k, input logic [1:0] i);
        return ({2'b00, k} * 4'd3) + {2'b00, i};
    endfunction

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic [1:0] prv3(input logic [1:0] i);
        return (i == 2'd0) ? 2'd2 : i - 2'd1;
    endfunction

    function automatic logic signed [65:0] scale_src(input ttf_pkg::t_src s,
                                                     input logic signed [63:0] tn,
                                                     input logic signed [63:0] bn,
                                                     input logic signed [35:0] w);
        logic signed [65:0] v;
        v = 66'(w);
        case (s)
            ttf_pkg::SRC_TNUM: v = 66'(tn);
            ttf_pkg::SRC_BNUM: v = 66'(bn);
            default:           v = 66'(w);
        endcase
        return v;
    endfunction

    assign vtx_acc  = i_vtx.valid && i_vtx.ready;
    assign slot     = r_phase[1] ? 2'd2 : r_phase;
    assign div_last = r_div_tan ? 5'd14 : 5'd31;

    // Shared multiply-accumulate and compare-subtract units.
    assign mac_prod = mac_a * mac_b;
    assign mac_term = mac_shl ? (mac_prod <<< 24) : mac_prod;
    assign n_acc    = mac_sub ? ((mac_clr ? 66'sd0 : r_acc) - mac_term)
                              : ((mac_clr ? 66'sd0 : r_acc) + mac_term);
    assign cs_ge    = cs_a >= cs_b;
    assign cs_diff  = cs_a - cs_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttf_pkg::ST_IDLE: begin
                if (vtx_acc && slot == 2'd2) n_state = ttf_pkg::ST_DELTA;
            end
            ttf_pkg::ST_DELTA: begin
                if (r_cnt == 5'd9) n_state = ttf_pkg::ST_PRE;
            end
            ttf_pkg::ST_PRE: begin
                if (r_cnt == 5'd13) begin
                    n_state = (r_det == 64'sd0) ? ttf_pkg::ST_OUT : ttf_pkg::ST_SCALE_MAX;
                end
            end
            ttf_pkg::ST_SCALE_MAX: n_state = ttf_pkg::ST_SCALE_WR;
            ttf_pkg::ST_SCALE_WR: begin
                if (r_idx == 2'd2) begin
                    case (r_src)
                        ttf_pkg::SRC_TNUM: n_state = ttf_pkg::ST_SCALE_MAX;
                        ttf_pkg::SRC_BNUM: n_state = ttf_pkg::ST_BSET;
                        default:           n_state = ttf_pkg::ST_SQ;
                    endcase
                end
            end
            ttf_pkg::ST_BSET: begin
                if (r_bnum[r_idx] == 64'sd0 || cs_ge) begin
                    n_state = (r_idx == 2'd2) ? ttf_pkg::ST_DOT : ttf_pkg::ST_BSET;
                end else begin
                    n_state = ttf_pkg::ST_DIV;
                end
            end
            ttf_pkg::ST_DIV: begin
                if (r_cnt == div_last) n_state = r_div_tan ? ttf_pkg::ST_TFIN : ttf_pkg::ST_BFIN;
            end
            ttf_pkg::ST_BFIN: n_state = (r_idx == 2'd2) ? ttf_pkg::ST_DOT : ttf_pkg::ST_BSET;
            ttf_pkg::ST_DOT: begin
                if (r_cnt == 5'd2) n_state = ttf_pkg::ST_ND;
            end
            ttf_pkg::ST_ND: begin
                if (r_cnt == 5'd5) n_state = ttf_pkg::ST_SCALE_MAX;
            end
            ttf_pkg::ST_SQ: begin
                if (r_cnt == 5'd2) begin
                    n_state = (n_acc == 66'sd0) ? ttf_pkg::ST_OUT : ttf_pkg::ST_SQRT;
                end
            end
            ttf_pkg::ST_SQRT: begin
                if (r_cnt == 5'd31) n_state = ttf_pkg::ST_TSET;
            end
            ttf_pkg::ST_TSET: n_state = ttf_pkg::ST_DIV;
            ttf_pkg::ST_TFIN: n_state = (r_idx == 2'd2) ? ttf_pkg::ST_CROSS : ttf_pkg::ST_TSET;
            ttf_pkg::ST_CROSS: begin
                if (r_cnt == 5'd5) n_state = ttf_pkg::ST_SDOT;
            end
            ttf_pkg::ST_SDOT: begin
                if (r_cnt == 5'd2) n_state = ttf_pkg::ST_OUT;
            end
            ttf_pkg::ST_OUT: begin
                if (o_res.ready) begin
                    if (r_vtx == 2'd2) begin
                        n_state = ttf_pkg::ST_IDLE;
                    end else begin
                        n_state = r_degen ? ttf_pkg::ST_OUT : ttf_pkg::ST_DOT;
                    end
                end
            end
            default: n_state = ttf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        logic [3:0] ia;
        logic [3:0] ib;
        logic [2:0] j;
        logic [1:0] k;
        logic [63:0] am;
        mac_a   = '0;
        mac_b   = '0;
        mac_clr = 1'b0;
        mac_sub = 1'b0;
        mac_shl = 1'b0;
        cs_a    = '0;
        cs_b    = '0;
        ia      = '0;
        ib      = '0;
        j       = r_cnt[3:1];
        k       = r_cnt[2:1];
        am      = '0;
        unique case (r_state)
            ttf_pkg::ST_PRE: begin
                case (j)
                    3'd0: begin
                        ia = r_cnt[0] ? 4'd7 : 4'd6;
                        ib = r_cnt[0] ? 4'd8 : 4'd9;
                    end
                    3'd1, 3'd2, 3'd3: begin
                        ia = r_cnt[0] ? (4'(j) + 4'd2) : (4'(j) - 4'd1);
                        ib = r_cnt[0] ? 4'd7 : 4'd9;
                    end
                    default: begin
                        ia = r_cnt[0] ? (4'(j) - 4'd4) : (4'(j) - 4'd1);
                        ib = r_cnt[0] ? 4'd8 : 4'd6;
                    end
                endcase
                mac_a   = 33'(r_dlt[ia]);
                mac_b   = 33'(r_dlt[ib]);
                mac_clr = !r_cnt[0];
                mac_sub = r_cnt[0];
            end
            ttf_pkg::ST_BSET: begin
                am   = mag(66'(r_bnum[r_idx]));
                cs_a = {17'd0, am[63:16]};
                cs_b = {1'b0, mag(66'(r_det))};
            end
            ttf_pkg::ST_DIV: begin
                cs_a = {r_rem, r_dlo[31]};
                cs_b = {1'b0, r_dd};
            end
            ttf_pkg::ST_DOT: begin
                mac_a   = 33'(r_nrm[vidx(r_vtx, r_cnt[1:0])]);
                mac_b   = 33'(r_tdir[r_cnt[1:0]]);
                mac_clr = (r_cnt == 5'd0);
            end
            ttf_pkg::ST_ND: begin
                mac_a = 33'(r_nrm[vidx(r_vtx, k)]);
                if (r_cnt[0]) begin
                    mac_b = $signed({9'd0, r_dot[23:0]});
                end else begin
                    mac_b   = 33'($signed(r_dot[48:24]));
                    mac_clr = 1'b1;
                    mac_shl = 1'b1;
                end
            end
            ttf_pkg::ST_SQ: begin
                mac_a   = $signed(r_w[r_cnt[1:0]][32:0]);
                mac_b   = $signed(r_w[r_cnt[1:0]][32:0]);
                mac_clr = (r_cnt == 5'd0);
            end
            ttf_pkg::ST_SQRT: begin
                cs_a = {1'b0, r_x};
                cs_b = 65'(r_r) + 65'(r_bitm);
            end
            ttf_pkg::ST_CROSS: begin
                if (r_cnt[0]) begin
                    mac_a   = 33'(r_nrm[vidx(r_vtx, prv3(k))]);
                    mac_b   = 33'(r_t[nxt3(k)]);
                    mac_sub = 1'b1;
                end else begin
                    mac_a   = 33'(r_nrm[vidx(r_vtx, nxt3(k))]);
                    mac_b   = 33'(r_t[prv3(k)]);
                    mac_clr = 1'b1;
                end
            end
            ttf_pkg::ST_SDOT: begin
                mac_a   = 33'(r_c[r_cnt[1:0]]);
                mac_b   = 33'(r_bdir[r_cnt[1:0]]);
                mac_clr = (r_cnt == 5'd0);
            end
            default: begin
            end
        endcase
    end

    assign i_vtx.ready            = (r_state == ttf_pkg::ST_IDLE);
    assign o_res.valid            = (r_state == ttf_pkg::ST_OUT);
    assign o_res.tan_x            = r_t[0];
    assign o_res.tan_y            = r_t[1];
    assign o_res.tan_z            = r_t[2];
    assign o_res.bitan_x          = r_bit[0];
    assign o_res.bitan_y          = r_bit[1];
    assign o_res.bitan_z          = r_bit[2];
    assign o_res.degenerate       = r_degen;
    assign o_res.last_of_triangle = (r_vtx == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ttf_pkg::ST_IDLE;
            r_phase   <= 2'd0;
            r_cnt     <= 5'd0;
            r_idx     <= 2'd0;
            r_vtx     <= 2'd0;
            r_src     <= ttf_pkg::SRC_TNUM;
            r_div_tan <= 1'b0;
            r_degen   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state == r_state) ? r_cnt + 5'd1 : 5'd0;
            unique case (r_state)
                ttf_pkg::ST_IDLE: begin
                    if (vtx_acc) begin
                        r_phase <= (slot == 2'd2) ? 2'd0 : r_phase + 2'd1;
                        r_vtx   <= 2'd0;
                    end
                end
                ttf_pkg::ST_PRE: begin
                    r_src   <= ttf_pkg::SRC_TNUM;
                    r_degen <= (r_det == 64'sd0);
                end
                ttf_pkg::ST_SCALE_MAX: r_idx <= 2'd0;
                ttf_pkg::ST_SCALE_WR: begin
                    r_idx <= nxt3(r_idx);
                    if (r_idx == 2'd2 && r_src == ttf_pkg::SRC_TNUM) begin
                        r_src <= ttf_pkg::SRC_BNUM;
                    end
                end
                ttf_pkg::ST_BSET: begin
                    r_div_tan <= 1'b0;
                    if (n_state != ttf_pkg::ST_DIV) r_idx <= nxt3(r_idx);
                end
                ttf_pkg::ST_BFIN: r_idx <= nxt3(r_idx);
                ttf_pkg::ST_ND:   r_src <= ttf_pkg::SRC_W;
                ttf_pkg::ST_TSET: r_div_tan <= 1'b1;
                ttf_pkg::ST_TFIN: r_idx <= nxt3(r_idx);
                ttf_pkg::ST_OUT: begin
                    if (o_res.ready) r_vtx <= r_vtx + 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] am;
        logic [63:0] sm;
        logic [63:0] sv;
        logic [6:0]  shn;
        logic signed [31:0] sval;
        logic signed [65:0] srcv;
        logic [64:0] dt;
        logic        neg;
        logic [31:0] qc;
        logic [63:0] ndm;
        logic signed [35:0] qs;
        logic [30:0] aw;
        logic [3:0]  pb;
        logic [2:0]  ua;
        logic [2:0]  ub;
        am   = '0;
        sm   = '0;
        sv   = '0;
        shn  = '0;
        sval = '0;
        srcv = '0;
        dt   = '0;
        neg  = 1'b0;
        qc   = '0;
        ndm  = '0;
        qs   = '0;
        aw   = '0;
        pb   = '0;
        ua   = '0;
        ub   = '0;
        unique case (r_state)
            ttf_pkg::ST_IDLE: begin
                if (vtx_acc) begin
                    r_pos[vidx(slot, 2'd0)] <= i_vtx.pos_x;
                    r_pos[vidx(slot, 2'd1)] <= i_vtx.pos_y;
                    r_pos[vidx(slot, 2'd2)] <= i_vtx.pos_z;
                    r_uv[{slot, 1'b0}]      <= i_vtx.tex_u;
                    r_uv[{slot, 1'b1}]      <= i_vtx.tex_v;
                    r_nrm[vidx(slot, 2'd0)] <= i_vtx.norm_x;
                    r_nrm[vidx(slot, 2'd1)] <= i_vtx.norm_y;
                    r_nrm[vidx(slot, 2'd2)] <= i_vtx.norm_z;
                end
            end
            ttf_pkg::ST_DELTA: begin
                if (r_cnt < 5'd6) begin
                    pb = (r_cnt < 5'd3) ? r_cnt[3:0] : r_cnt[3:0] - 4'd3;
                    r_dlt[r_cnt[3:0]] <= sat_sub(r_pos[r_cnt[3:0] + 4'd3], r_pos[pb]);
                end else begin
                    ua = 3'(r_cnt - 5'd4);
                    ub = (r_cnt < 5'd8) ? 3'(r_cnt - 5'd6) : 3'(r_cnt - 5'd8);
                    r_dlt[r_cnt[3:0]] <= sat_sub(r_uv[ua], r_uv[ub]);
                end
            end
            ttf_pkg::ST_PRE: begin
                r_acc <= n_acc;
                if (r_cnt[0]) begin
                    if (r_cnt[3:1] == 3'd0) begin
                        r_det <= n_acc[63:0];
                    end else if (r_cnt[3:1] < 3'd4) begin
                        r_tnum[2'(r_cnt[3:1] - 3'd1)] <= n_acc[63:0];
                    end else begin
                        r_bnum[2'(r_cnt[3:1] - 3'd4)] <= n_acc[63:0];
                    end
                end
                if (r_cnt == 5'd13 && r_det == 64'sd0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_t[i]   <= '0;
                        r_bit[i] <= '0;
                    end
                end
            end
            ttf_pkg::ST_SCALE_MAX: begin
                for (int i = 0; i < 3; i++) begin
                    sm = sm | mag(scale_src(r_src, r_tnum[i], r_bnum[i], r_w[i]));
                end
                r_sh <= $signed({1'b0, msb64(sm)}) - 7'sd29;
            end
            ttf_pkg::ST_SCALE_WR: begin
                srcv = scale_src(r_src, r_tnum[r_idx], r_bnum[r_idx], r_w[r_idx]);
                am   = mag(srcv);
                shn  = -r_sh;
                sv   = r_sh[6] ? (am << shn[5:0]) : (am >> r_sh[5:0]);
                neg  = srcv[65] ^ (r_src != ttf_pkg::SRC_W && r_det[63]);
                sval = $signed({1'b0, sv[30:0]});
                if (neg) sval = -sval;
                case (r_src)
                    ttf_pkg::SRC_TNUM: r_tdir[r_idx] <= sval;
                    ttf_pkg::SRC_BNUM: r_bdir[r_idx] <= sval;
                    default:           r_w[r_idx]    <= 36'(sval);
                endcase
            end
            ttf_pkg::ST_BSET: begin
                am  = mag(66'(r_bnum[r_idx]));
                neg = r_bnum[r_idx][63] ^ r_det[63];
                if (r_bnum[r_idx] == 64'sd0) begin
                    r_bit[r_idx] <= '0;
                end else if (cs_ge) begin
                    r_bit[r_idx] <= neg ? $signed(ttf_pkg::LimNeg) : $signed(ttf_pkg::LimPos);
                end else begin
                    r_rem <= {16'd0, am[63:16]};
                    r_dlo <= {am[15:0], 16'd0};
                    r_dd  <= mag(66'(r_det));
                    r_q   <= '0;
                end
            end
            ttf_pkg::ST_DIV: begin
                dt    = {r_rem, r_dlo[31]};
                r_rem <= cs_ge ? cs_diff[63:0] : dt[63:0];
                r_q   <= {r_q[30:0], cs_ge};
                r_dlo <= {r_dlo[30:0], 1'b0};
            end
            ttf_pkg::ST_BFIN: begin
                neg = r_bnum[r_idx][63] ^ r_det[63];
                qc  = r_q;
                if (neg && qc > ttf_pkg::LimNeg) qc = ttf_pkg::LimNeg;
                if (!neg && qc > ttf_pkg::LimPos) qc = ttf_pkg::LimPos;
                r_bit[r_idx] <= neg ? -$signed(qc) : $signed(qc);
            end
            ttf_pkg::ST_DOT: begin
                r_acc <= n_acc;
                if (r_cnt == 5'd2) r_dot <= n_acc[48:0];
            end
            ttf_pkg::ST_ND: begin
                r_acc <= n_acc;
                if (r_cnt[0]) begin
                    ndm = mag(n_acc);
                    qs  = $signed(ndm[63:28]);
                    if (n_acc[65]) qs = -qs;
                    r_w[r_cnt[2:1]] <= 36'(r_tdir[r_cnt[2:1]]) - qs;
                end
            end
            ttf_pkg::ST_SQ: begin
                r_acc <= n_acc;
                if (r_cnt == 5'd2) begin
                    r_x    <= n_acc[63:0];
                    r_r    <= '0;
                    r_bitm <= 64'h4000_0000_0000_0000;
                    if (n_acc == 66'sd0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_t[i] <= '0;
                        end
                    end
                end
            end
            ttf_pkg::ST_SQRT: begin
                if (cs_ge) begin
                    r_x <= cs_diff[63:0];
                    r_r <= (r_r >> 1) + r_bitm;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bitm <= r_bitm >> 2;
            end
            ttf_pkg::ST_TSET: begin
                am    = mag(66'(r_w[r_idx]));
                aw    = am[30:0];
                r_rem <= 64'(aw >> 1);
                r_dlo <= {aw[0], 31'd0};
                r_dd  <= r_r;
                r_q   <= '0;
            end
            ttf_pkg::ST_TFIN: begin
                r_t[r_idx] <= r_w[r_idx][35] ? -$signed(r_q[15:0]) : $signed(r_q[15:0]);
            end
            ttf_pkg::ST_CROSS: begin
                r_acc <= n_acc;
                if (r_cnt[0]) r_c[r_cnt[2:1]] <= n_acc[31:0];
            end
            ttf_pkg::ST_SDOT: begin
                r_acc <= n_acc;
                if (r_cnt == 5'd2 && n_acc[65]) begin
                    for (int i = 0; i < 3; i++) begin
                        r_t[i] <= -r_t[i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
